@@ src/b58dec_pkg.sv @@
// Shared constants, types and the digit lookup of the Base58 text decoder.
package b58dec_pkg;

  // Longest accepted string in non-whitespace symbols; also the byte store depth
  localparam int unsigned MAX_CHARS = 64;
  localparam int unsigned AW        = $clog2(MAX_CHARS);      // store address
  localparam int unsigned CW        = $clog2(MAX_CHARS + 1);  // counts 0..MAX_CHARS
  localparam int unsigned DIGIT_W   = 6;                      // digit 0..57
  localparam int unsigned CARRY_W   = 6;                      // carry stays below 58
  localparam int unsigned SUM_W     = 14;                     // 58*255 + 57
  localparam logic [7:0]  RADIX     = 8'd58;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_CHAR    = 2'd1,
    ST_AFTER_SPACE = 2'd2,
    ST_TOO_LONG    = 2'd3
  } status_e;

  // Parse phase of the current string
  typedef enum logic [1:0] {
    PH_LEAD_SPACE = 2'd0,
    PH_LEAD_ONES  = 2'd1,
    PH_DIGITS     = 2'd2,
    PH_TRAIL_SPACE = 2'd3
  } phase_e;

  typedef struct packed {
    logic               ok;
    logic [DIGIT_W-1:0] val;
  } digit_t;

  // Tab, LF, VT, FF, CR and space
  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  // Bitcoin alphabet: 1-9, A-H, J-N, P-Z, a-k, m-z
  function automatic digit_t b58_digit(input logic [7:0] c);
    digit_t d;
    d.ok  = 1'b1;
    d.val = '0;
    if (c >= 8'h31 && c <= 8'h39) begin
      d.val = DIGIT_W'(c - 8'h31);
    end else if (c >= 8'h41 && c <= 8'h48) begin
      d.val = DIGIT_W'(c - 8'h41 + 8'd9);
    end else if (c >= 8'h4A && c <= 8'h4E) begin
      d.val = DIGIT_W'(c - 8'h4A + 8'd17);
    end else if (c >= 8'h50 && c <= 8'h5A) begin
      d.val = DIGIT_W'(c - 8'h50 + 8'd22);
    end else if (c >= 8'h61 && c <= 8'h6B) begin
      d.val = DIGIT_W'(c - 8'h61 + 8'd33);
    end else if (c >= 8'h6D && c <= 8'h7A) begin
      d.val = DIGIT_W'(c - 8'h6D + 8'd44);
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

endpackage

@@ src/base58_text_decoder.sv @@
// Base58 text decoder: character stream in, big-endian decoded bytes out.
//
// One ASCII character per input beat, tlast set on the beat that closes the
// string (its data is ignored). Whitespace and leading '1' characters are
// absorbed in the idle state. Every other digit starts a walk: a single
// 8x6-bit multiply-by-58-and-add unit walks the whole byte store, one byte
// per cycle through the store's single read and write port. On the closing
// beat the block emits one zero byte per leading '1' and then the value
// without its leading zero bytes, each byte passing the read and load states;
// a bad string or an empty value gives one result beat instead. tuser flags
// byte_valid and the status code; tlast marks the final beat of a run.
// Input is not taken while a digit or an output run is in progress.
module base58_text_decoder
  import b58dec_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  // input stream
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] symbol
  input  logic       s_axis_tlast_i,   // end_mark
  // output stream
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic [2:0] m_axis_tuser_o,   // [0] byte_valid, [2:1] status
  output logic       m_axis_tlast_o    // last
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_RD,
    S_LOAD,
    S_FINAL
  } state_e;

  localparam logic [CW:0]   MaxExt  = (CW+1)'(MAX_CHARS);
  localparam logic [AW-1:0] TopAddr = AW'(MAX_CHARS - 1);

  state_e             state_q;
  status_e            err_q;
  status_e            fin_status_q;
  phase_e             phase_q;
  logic [CW-1:0]      count_q;
  logic [CW-1:0]      ones_q;
  logic [CW-1:0]      first_q;    // index of first nonzero byte, MAX_CHARS if none
  logic [CW-1:0]      scan_q;     // smallest nonzero index seen in this pass
  logic [CW-1:0]      total_q;
  logic [CW-1:0]      k_q;
  logic [AW-1:0]      idx_q;      // next read address of the walk
  logic               issue_q;
  logic               rpend_q;
  logic [AW-1:0]      ridx_q;     // address whose data sits in rdata_q
  logic [CARRY_W-1:0] carry_q;
  logic [MAX_CHARS-1:0] vld_q;
  logic               rv_q;

  logic [7:0]         mem_q [MAX_CHARS];
  logic [7:0]         rdata_q;

  logic               m_valid_q;
  logic [7:0]         m_data_q;
  logic [2:0]         m_user_q;
  logic               m_last_q;

  // Input beat decode
  logic               s_fire;
  digit_t             dig;
  logic               sym_space;
  logic [CW:0]        total_raw;
  logic [CW-1:0]      total_w;

  // Shared multiply-add unit
  logic [7:0]         rbyte;
  logic [SUM_W-1:0]   sum;
  logic               wr_en;

  // Output side
  logic               out_free;
  logic               out_load;
  logic [AW-1:0]      emit_addr;
  logic [AW-1:0]      rd_addr;
  logic               emit_zero;
  logic               emit_last;
  logic [CW-1:0]      emit_off;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign dig             = b58_digit(s_axis_tdata_i);
  assign sym_space       = is_space(s_axis_tdata_i);

  // Output count: leading zeros plus significant bytes, capped at the store depth
  assign total_raw = (CW+1)'(ones_q) + MaxExt - (CW+1)'(first_q);
  assign total_w   = (total_raw > MaxExt) ? CW'(MAX_CHARS) : CW'(total_raw);

  // Multiply by 58 and add carry; a never-written byte reads as zero
  assign rbyte = rv_q ? rdata_q : 8'd0;
  assign sum   = SUM_W'(RADIX) * SUM_W'(rbyte) + SUM_W'(carry_q);
  assign wr_en = (state_q == S_MUL) && rpend_q;

  // Emit address: byte index after the leading zeros
  assign emit_zero = (k_q < ones_q);
  assign emit_off  = first_q + (k_q - ones_q);
  assign emit_addr = emit_off[AW-1:0];
  assign emit_last = (k_q == total_q - CW'(1));
  assign rd_addr   = (state_q == S_MUL) ? idx_q : emit_addr;

  assign out_free  = !m_valid_q || m_axis_tready_i;
  assign out_load  = ((state_q == S_LOAD) || (state_q == S_FINAL)) && out_free;

  // Byte store: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[ridx_q] <= sum[7:0];
    end
    rdata_q <= mem_q[rd_addr];
  end

  // Sequencer, run state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      err_q        <= ST_OK;
      fin_status_q <= ST_OK;
      phase_q      <= PH_LEAD_SPACE;
      count_q      <= '0;
      ones_q       <= '0;
      first_q      <= CW'(MAX_CHARS);
      scan_q       <= CW'(MAX_CHARS);
      total_q      <= '0;
      k_q          <= '0;
      idx_q        <= '0;
      issue_q      <= 1'b0;
      rpend_q      <= 1'b0;
      ridx_q       <= '0;
      carry_q      <= '0;
      vld_q        <= '0;
      rv_q         <= 1'b0;
      m_valid_q    <= 1'b0;
      m_data_q     <= '0;
      m_user_q     <= '0;
      m_last_q     <= 1'b0;
    end else begin
      rv_q <= vld_q[rd_addr];
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (s_fire && s_axis_tlast_i) begin
            // end of string
            k_q     <= '0;
            total_q <= total_w;
            if (err_q != ST_OK) begin
              fin_status_q <= err_q;
              state_q      <= S_FINAL;
            end else if (total_w == '0) begin
              fin_status_q <= ST_OK;
              state_q      <= S_FINAL;
            end else begin
              state_q <= S_RD;
            end
          end else if (s_fire && err_q == ST_OK) begin
            priority if (sym_space) begin
              if (phase_q != PH_LEAD_SPACE) begin
                phase_q <= PH_TRAIL_SPACE;
              end
            end else if (phase_q == PH_TRAIL_SPACE) begin
              err_q <= ST_AFTER_SPACE;
            end else if (!dig.ok) begin
              err_q <= ST_BAD_CHAR;
            end else if (count_q >= CW'(MAX_CHARS)) begin
              err_q <= ST_TOO_LONG;
            end else begin
              count_q <= count_q + CW'(1);
              if (dig.val == '0 && phase_q != PH_DIGITS) begin
                ones_q  <= ones_q + CW'(1);
                phase_q <= PH_LEAD_ONES;
              end else begin
                // start a store walk from the least significant byte
                phase_q <= PH_DIGITS;
                carry_q <= CARRY_W'(dig.val);
                idx_q   <= TopAddr;
                issue_q <= 1'b1;
                rpend_q <= 1'b0;
                scan_q  <= CW'(MAX_CHARS);
                state_q <= S_MUL;
              end
            end
          end
        end

        S_MUL: begin
          // read stage
          rpend_q <= issue_q;
          ridx_q  <= idx_q;
          if (issue_q) begin
            if (idx_q == '0) begin
              issue_q <= 1'b0;
            end else begin
              idx_q <= idx_q - AW'(1);
            end
          end
          // multiply-add and write-back stage
          if (rpend_q) begin
            vld_q[ridx_q] <= 1'b1;
            carry_q       <= sum[SUM_W-1:8];
            if (ridx_q == '0) begin
              first_q <= (sum[7:0] != 8'd0) ? '0 : scan_q;
              state_q <= S_IDLE;
            end else if (sum[7:0] != 8'd0) begin
              scan_q <= CW'(ridx_q);
            end
          end
        end

        S_RD: begin
          state_q <= S_LOAD;
        end

        S_LOAD: begin
          if (out_free) begin
            m_data_q  <= emit_zero ? 8'd0 : rbyte;
            m_user_q  <= {ST_OK, 1'b1};
            m_last_q  <= emit_last;
            if (emit_last) begin
              err_q   <= ST_OK;
              phase_q <= PH_LEAD_SPACE;
              count_q <= '0;
              ones_q  <= '0;
              first_q <= CW'(MAX_CHARS);
              vld_q   <= '0;
              state_q <= S_IDLE;
            end else begin
              k_q     <= k_q + CW'(1);
              state_q <= S_RD;
            end
          end
        end

        S_FINAL: begin
          if (out_free) begin
            m_data_q  <= 8'd0;
            m_user_q  <= {fin_status_q, 1'b0};
            m_last_q  <= 1'b1;
            err_q     <= ST_OK;
            phase_q   <= PH_LEAD_SPACE;
            count_q   <= '0;
            ones_q    <= '0;
            first_q   <= CW'(MAX_CHARS);
            vld_q     <= '0;
            state_q   <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;
  assign m_axis_tlast_o  = m_last_q;

  // Leading ones are a subset of the counted symbols
  a_ones_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ones_q <= count_q)
    else $error("leading-one count exceeds symbol count");

  // The store is only written after a clean digit was accepted
  a_write_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (err_q == ST_OK) && (phase_q == PH_DIGITS))
    else $error("store write outside digit phase");

  // A new output beat is only produced by the output states
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> ($past(state_q) == S_LOAD || $past(state_q) == S_FINAL))
    else $error("output beat from wrong state");

  // Emitting the final byte clears the run state
  a_run_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD && out_free && emit_last) |=>
      (count_q == '0 && ones_q == '0 && vld_q == '0 && state_q == S_IDLE))
    else $error("run state not cleared after last byte");

  // An output run never exceeds the store depth
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD) |-> (k_q < total_q) && (total_q <= CW'(MAX_CHARS)))
    else $error("output index out of range");

endmodule

@@ tb/tb_base58_text_decoder.sv @@
// Self-checking testbench for the Base58 text decoder: directed, length, stall and random runs.
`timescale 1ns / 100ps

module tb_base58_text_decoder;
  import b58dec_pkg::*;

  typedef logic [7:0] char_q_t[$];

  // One expected output beat
  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       last;
    status_e    status;
  } b58_beat_t;

  typedef enum int {RX_ALWAYS, RX_PATTERN, RX_RANDOM} rx_mode_e;

  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i  = 8'h00;   // [7:0] symbol
  logic       s_axis_tlast_i  = 1'b0;    // end_mark
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;            // [7:0] out_byte
  logic [2:0] m_axis_tuser_o;            // [0] byte_valid, [2:1] status
  logic       m_axis_tlast_o;

  string b58_chars = "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

  // Decoder state mirrored by the predictor
  logic [7:0]  acc_bytes [MAX_CHARS];
  int unsigned char_count;
  int unsigned ones_count;
  phase_e      parse_phase;
  status_e     run_err;

  b58_beat_t   exp_beats[$];
  int unsigned mismatch_count = 0;
  int unsigned beats_sent     = 0;

  // Sender and receiver idling controls
  bit          gaps_on    = 1'b0;
  int unsigned burst_left = 0;
  rx_mode_e    rx_mode    = RX_ALWAYS;
  int unsigned hold_left  = 0;
  logic [7:0]  rx_pattern = 8'b1011_0110;

  base58_text_decoder i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic bit is_blank(logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic int digit_value(logic [7:0] c);
    for (int i = 0; i < 58; i++) begin
      if (b58_chars[i] == c) return i;
    end
    return -1;
  endfunction

  function automatic void restart_parse();
    foreach (acc_bytes[i]) acc_bytes[i] = 8'h00;
    char_count  = 0;
    ones_count  = 0;
    parse_phase = PH_LEAD_SPACE;
    run_err     = ST_OK;
  endfunction

  // value = value * 58 + digit over the big-endian store
  function automatic void times58_plus(int digit);
    int unsigned carry;
    carry = digit;
    for (int i = MAX_CHARS - 1; i >= 0; i--) begin
      carry        = carry + 58 * acc_bytes[i];
      acc_bytes[i] = carry[7:0];
      carry        = carry >> 8;
    end
  endfunction

  function automatic void absorb_char(logic [7:0] c);
    int d;
    if (run_err != ST_OK) return;
    if (is_blank(c)) begin
      if (parse_phase != PH_LEAD_SPACE) parse_phase = PH_TRAIL_SPACE;
      return;
    end
    if (parse_phase == PH_TRAIL_SPACE) begin
      run_err = ST_AFTER_SPACE;
      return;
    end
    d = digit_value(c);
    if (d < 0) begin
      run_err = ST_BAD_CHAR;
      return;
    end
    if (char_count >= MAX_CHARS) begin
      run_err = ST_TOO_LONG;
      return;
    end
    char_count++;
    // a '1' before any real digit is a leading zero byte
    if (d == 0 && parse_phase != PH_DIGITS) begin
      ones_count++;
      parse_phase = PH_LEAD_ONES;
      return;
    end
    parse_phase = PH_DIGITS;
    times58_plus(d);
  endfunction

  // End of string: queue the output run it causes
  function automatic void close_string();
    b58_beat_t beat;
    int        first;
    int        total;
    if (run_err != ST_OK) begin
      beat = '{data: 8'h00, byte_valid: 1'b0, last: 1'b1, status: run_err};
      exp_beats.insert(exp_beats.size(), beat);
    end else begin
      first = 0;
      while (first < MAX_CHARS && acc_bytes[first] == 8'h00) first++;
      total = ones_count + (MAX_CHARS - first);
      if (total > MAX_CHARS) total = MAX_CHARS;
      if (total == 0) begin
        beat = '{data: 8'h00, byte_valid: 1'b0, last: 1'b1, status: ST_OK};
        exp_beats.insert(exp_beats.size(), beat);
      end
      for (int k = 0; k < total; k++) begin
        beat.data       = (k < ones_count) ? 8'h00 : acc_bytes[first + k - ones_count];
        beat.byte_valid = 1'b1;
        beat.last       = (k == total - 1);
        beat.status     = ST_OK;
        exp_beats.insert(exp_beats.size(), beat);
      end
    end
    restart_parse();
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // Drive one beat at the falling edge, hold it until accepted
  task automatic send_beat(input logic [7:0] sym, input logic endm);
    @(negedge clk_i);
    if (gaps_on && burst_left == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left != 0) burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= sym;
    s_axis_tlast_i  <= endm;
    do @(posedge clk_i); while (!s_axis_tready_o);
    beats_sent++;
    if (endm) close_string();
    else absorb_char(sym);
  endtask

  // A string followed by the closing beat, whose data is don't-care
  task automatic send_run(input char_q_t txt);
    foreach (txt[i]) send_beat(txt[i], 1'b0);
    send_beat(8'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic char_q_t text_of(string s);
    char_q_t q;
    for (int i = 0; i < s.len(); i++) q.insert(q.size(), s[i]);
    return q;
  endfunction

  function automatic logic [7:0] blank_char();
    return ($urandom_range(0, 5) == 5) ? 8'd32 : 8'(9 + $urandom_range(0, 4));
  endfunction

  function automatic logic [7:0] b58_char();
    return b58_chars[$urandom_range(0, 57)];
  endfunction

  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (digit_value(c) >= 0 || is_blank(c));
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------
  // Receiver stall pattern plus long hold-offs counted here
  always @(negedge clk_i) begin
    logic ready;
    rx_pattern = {rx_pattern[6:0], rx_pattern[7]};
    case (rx_mode)
      RX_PATTERN: ready = rx_pattern[0];
      RX_RANDOM:  ready = ($urandom_range(0, 3) != 0);
      default:    ready = 1'b1;
    endcase
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      ready     = 1'b0;
    end
    m_axis_tready_i <= ready;
  end

  // Compare every accepted output beat with the oldest expectation
  always @(posedge clk_i) begin
    b58_beat_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (exp_beats.size() == 0) begin
        $error("unexpected output beat: data %0h user %0h last %0b",
               m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
        mismatch_count++;
      end else begin
        want = exp_beats.pop_front();
        if (m_axis_tdata_o !== want.data) begin
          $error("out_byte: expected %0h, got %0h", want.data, m_axis_tdata_o);
          mismatch_count++;
        end
        if (m_axis_tuser_o[0] !== want.byte_valid) begin
          $error("byte_valid: expected %0b, got %0b", want.byte_valid, m_axis_tuser_o[0]);
          mismatch_count++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, m_axis_tlast_o);
          mismatch_count++;
        end
        if (m_axis_tuser_o[2:1] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser_o[2:1]);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Short strings: empty, blanks, ones, single digits, bad characters and text after blanks
  task automatic test_directed();
    char_q_t txt;
    gaps_on = 1'b0;
    rx_mode = RX_ALWAYS;
    send_run(text_of(""));
    send_run(text_of("\t\n\v\f\r "));
    send_run(text_of("1"));
    send_run(text_of(" 111zz \t"));
    send_run(text_of("1z1"));
    send_run(text_of("2"));
    send_run(text_of("0OIl"));
    txt = {8'h00};
    send_run(txt);
    txt = {8'h31, 8'hFF, 8'h80};
    send_run(txt);
    send_run(text_of("ab c"));
    send_run(text_of("11 2"));
    // first error sticks: bad char, then text after blank
    txt = {8'h31, 8'h00, 8'h20, 8'h78};
    send_run(txt);
  endtask

  // Strings at and past the length bound, and the full alphabet
  task automatic test_length_bound();
    char_q_t txt;
    gaps_on = 1'b1;
    rx_mode = RX_PATTERN;
    send_run(text_of(b58_chars));
    txt = {};
    repeat (MAX_CHARS) txt.insert(txt.size(), "z");
    send_run(txt);
    txt = {};
    repeat (MAX_CHARS) txt.insert(txt.size(), "1");
    send_run(txt);
    txt.insert(txt.size(), "1");
    send_run(txt);
    // invalid symbol in the overflow slot outranks the length error
    txt[MAX_CHARS] = "0";
    send_run(txt);
    txt[MAX_CHARS] = " ";
    txt.insert(txt.size(), "x");
    send_run(txt);
  endtask

  // Long receiver hold-off while the sender keeps offering beats
  task automatic test_back_pressure();
    gaps_on = 1'b0;
    rx_mode = RX_ALWAYS;
    send_run(text_of("111Zy"));
    hold_left = 400;
    send_run(text_of(" 3yQ  "));
    send_run(text_of("11JxF9"));
  endtask

  // Mostly well-formed strings with random content, some broken or noisy
  task automatic random_run();
    char_q_t txt;
    int      kind;
    int      ones;
    int      digits;
    kind = $urandom_range(0, 19);
    repeat ($urandom_range(0, 2)) txt.insert(txt.size(), blank_char());
    if (kind == 19) begin
      repeat (MAX_CHARS + $urandom_range(1, 4)) txt.insert(txt.size(), b58_char());
    end else if (kind >= 17) begin
      repeat ($urandom_range(1, 6)) txt.insert(txt.size(), 8'($urandom_range(0, 255)));
    end else begin
      ones   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
      digits = ($urandom_range(0, 11) == 0) ? $urandom_range(11, MAX_CHARS - ones)
                                            : $urandom_range(0, 10);
      repeat (ones) txt.insert(txt.size(), "1");
      repeat (digits) txt.insert(txt.size(), b58_char());
      if (kind == 13 || kind == 14) begin
        txt.insert($urandom_range(0, txt.size()), junk_char());
      end else if (kind == 15 || kind == 16) begin
        txt.insert(txt.size(), blank_char());
        repeat ($urandom_range(1, 3)) txt.insert(txt.size(),
                                                 $urandom_range(0, 1) ? b58_char()
                                                                      : junk_char());
      end
    end
    repeat ($urandom_range(0, 2)) txt.insert(txt.size(), blank_char());
    send_run(txt);
  endtask

  // Random runs top the item count up to about 500
  task automatic test_random();
    int unsigned goal;
    goal = 500;
    while (beats_sent < goal) begin
      gaps_on = $urandom_range(0, 3) != 0;
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      random_run();
    end
  endtask

  initial begin
    restart_parse();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_length_bound();
    test_back_pressure();
    test_random();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (exp_beats.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ filelist.f @@
src/b58dec_pkg.sv
src/base58_text_decoder.sv
tb/tb_base58_text_decoder.sv
